// File: sv/physical_range_access_gate_defines.svh
// Assertion macros for the physical range access gate.
// Included by the modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef PHYSICAL_RANGE_ACCESS_GATE_DEFINES_SVH
`define PHYSICAL_RANGE_ACCESS_GATE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define PRAG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define PRAG_ASSERT_NEXT(label, ante, cons, msg) \
  `PRAG_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: sv/prag_pkg.sv
// Shared types, codes and helpers of the physical range access gate.
// Used by the controller, the datapath and the top level; no dependencies.
package prag_pkg;

  localparam int ADDR_W = 64;
  localparam int CFG_W  = 6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic [2:0] KIND_UNMAPPED = 3'd4;

  typedef enum logic [2:0] {
    REASON_OK         = 3'd0,
    REASON_ZERO_LEN   = 3'd1,
    REASON_MISALIGNED = 3'd2,
    REASON_WRAPS      = 3'd3,
    REASON_UNCOVERED  = 3'd4,
    REASON_POLICY     = 3'd5
  } reason_e;

  typedef enum logic [1:0] {
    CFG_REGION_COUNT = 2'd0,
    CFG_READ_MASK    = 2'd1,
    CFG_WRITE_MASK   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W:0]   rend;
    logic [2:0]        kind;
  } region_t;

  typedef struct packed {
    logic latch;
    logic load_wr;
    logic walk_init;
    logic search_init;
    logic idx_inc;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic zero_len;
    logic misalign;
    logic wraps;
    logic walk_end;
    logic idx_end;
    logic hit;
    logic unmapped;
    logic denied;
    logic rend_top;
  } dp_status_t;

  function automatic logic [3:0] align_mask(input logic [1:0] code);
    logic [3:0] m;
    unique case (code)
      2'd0:    m = 4'b0000;
      2'd1:    m = 4'b0001;
      2'd2:    m = 4'b0011;
      default: m = 4'b0111;
    endcase
    return m;
  endfunction

endpackage

// File: sv/prag_dp.sv
// Datapath of the physical range access gate: input latches, configuration,
// region table memory, walk registers and compare logic. Depends on prag_pkg.
module prag_dp #(
  parameter int REGION_ENTRIES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  prag_pkg::ctrl_cmd_t         cmd_i,
  output prag_pkg::dp_status_t        status_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [prag_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        command_i,
  input  logic [4:0]                  entry_index_i,
  input  logic [prag_pkg::ADDR_W-1:0] entry_base_i,
  input  logic [prag_pkg::ADDR_W-1:0] entry_length_i,
  input  logic [2:0]                  entry_type_i,
  input  logic [prag_pkg::ADDR_W-1:0] start_address_i,
  input  logic [prag_pkg::ADDR_W-1:0] range_length_i,
  input  logic                        write_access_i,
  input  logic [1:0]                  width_code_i
);

  localparam int IDX_W  = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(REGION_ENTRIES + 1);
  localparam int STEP_W = $clog2(REGION_ENTRIES + 2);
  localparam int AW     = prag_pkg::ADDR_W;

  logic          command_q;
  logic [4:0]    entry_index_q;
  logic [AW-1:0] entry_base_q;
  logic [AW-1:0] entry_length_q;
  logic [2:0]    entry_type_q;
  logic [AW-1:0] start_q;
  logic [AW-1:0] len_q;
  logic          write_access_q;
  logic [1:0]    width_code_q;

  logic [prag_pkg::CFG_W-1:0] region_count_q;
  logic [3:0]                 read_mask_q;
  logic [3:0]                 write_mask_q;

  logic [AW-1:0]     cur_q;
  logic [AW-1:0]     end_q;
  logic [STEP_W-1:0] steps_q;
  logic [CNT_W-1:0]  idx_q;

  prag_pkg::region_t region_mem [REGION_ENTRIES];
  prag_pkg::region_t rd_q;
  prag_pkg::region_t wr_entry;

  logic [31:0]    slot_ext;
  logic [IDX_W-1:0] wr_addr;
  logic           mem_we;
  logic [AW:0]    range_sum;
  logic [3:0]     policy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      command_q      <= command_i;
      entry_index_q  <= entry_index_i;
      entry_base_q   <= entry_base_i;
      entry_length_q <= entry_length_i;
      entry_type_q   <= entry_type_i;
      start_q        <= start_address_i;
      len_q          <= range_length_i;
      write_access_q <= write_access_i;
      width_code_q   <= width_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_count_q <= '0;
      read_mask_q    <= 4'hf;
      write_mask_q   <= 4'hf;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        prag_pkg::CFG_REGION_COUNT: region_count_q <= cfg_data_i;
        prag_pkg::CFG_READ_MASK:    read_mask_q    <= cfg_data_i[3:0];
        prag_pkg::CFG_WRITE_MASK:   write_mask_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign slot_ext       = 32'(entry_index_q);
  assign wr_addr        = slot_ext[IDX_W-1:0];
  assign mem_we         = cmd_i.load_wr && (slot_ext < 32'(REGION_ENTRIES));
  assign wr_entry.base  = entry_base_q;
  assign wr_entry.rend  = {1'b0, entry_base_q} + {1'b0, entry_length_q};
  assign wr_entry.kind  = entry_type_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      region_mem[wr_addr] <= wr_entry;
    end
    rd_q <= region_mem[idx_q[IDX_W-1:0]];
  end

  assign range_sum = {1'b0, start_q} + {1'b0, len_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      cur_q <= start_q;
      end_q <= range_sum[AW-1:0];
    end else if (cmd_i.advance) begin
      cur_q <= rd_q.rend[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.walk_init) begin
        steps_q <= '0;
      end else if (cmd_i.advance) begin
        steps_q <= steps_q + STEP_W'(1);
      end
      if (cmd_i.search_init) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  assign policy = write_access_q ? write_mask_q : read_mask_q;

  always_comb begin
    status_o.is_load  = (command_q == prag_pkg::CMD_LOAD);
    status_o.zero_len = (len_q == '0);
    status_o.misalign = |((start_q[3:0] | len_q[3:0]) & prag_pkg::align_mask(width_code_q));
    status_o.wraps    = range_sum[AW];
    status_o.walk_end = (32'(steps_q) > 32'(REGION_ENTRIES)) || (cur_q >= end_q);
    status_o.idx_end  = (32'(idx_q) >= 32'(region_count_q)) ||
                        (32'(idx_q) >= 32'(REGION_ENTRIES));
    status_o.hit      = (cur_q >= rd_q.base) && ({1'b0, cur_q} < rd_q.rend);
    status_o.unmapped = (rd_q.kind >= prag_pkg::KIND_UNMAPPED);
    status_o.denied   = !policy[rd_q.kind[1:0]];
    status_o.rend_top = rd_q.rend[AW];
  end

endmodule

// File: sv/prag_ctrl.sv
// Controller of the physical range access gate: sequences loads, validation
// and the region walk, and registers the result. Depends on prag_pkg and the defines header.
`include "physical_range_access_gate_defines.svh"

module prag_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  prag_pkg::dp_status_t status_i,
  output prag_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o,
  output logic                 done_o,
  output logic                 allowed_o,
  output logic [2:0]           reason_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NEXT,
    ST_READ,
    ST_MATCH
  } state_e;

  state_e            state_q, state_d;
  logic              done_q, done_d;
  logic              allowed_q, allowed_d;
  prag_pkg::reason_e reason_q, reason_d;

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    reason_d = reason_q;
    cmd_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.is_load) begin
          cmd_o.load_wr = 1'b1;
          done_d        = 1'b1;
          reason_d      = prag_pkg::REASON_OK;
          state_d       = ST_IDLE;
        end else if (status_i.zero_len) begin
          done_d   = 1'b1;
          reason_d = prag_pkg::REASON_ZERO_LEN;
          state_d  = ST_IDLE;
        end else if (status_i.misalign) begin
          done_d   = 1'b1;
          reason_d = prag_pkg::REASON_MISALIGNED;
          state_d  = ST_IDLE;
        end else if (status_i.wraps) begin
          done_d   = 1'b1;
          reason_d = prag_pkg::REASON_WRAPS;
          state_d  = ST_IDLE;
        end else begin
          cmd_o.walk_init = 1'b1;
          state_d         = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (status_i.walk_end) begin
          done_d   = 1'b1;
          reason_d = prag_pkg::REASON_OK;
          state_d  = ST_IDLE;
        end else begin
          cmd_o.search_init = 1'b1;
          state_d           = ST_READ;
        end
      end
      ST_READ: begin
        if (status_i.idx_end) begin
          done_d   = 1'b1;
          reason_d = prag_pkg::REASON_UNCOVERED;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (!status_i.hit) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_READ;
        end else if (status_i.unmapped) begin
          done_d   = 1'b1;
          reason_d = prag_pkg::REASON_UNCOVERED;
          state_d  = ST_IDLE;
        end else if (status_i.denied) begin
          done_d   = 1'b1;
          reason_d = prag_pkg::REASON_POLICY;
          state_d  = ST_IDLE;
        end else if (status_i.rend_top) begin
          done_d   = 1'b1;
          reason_d = prag_pkg::REASON_OK;
          state_d  = ST_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_NEXT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    allowed_d = (reason_d == prag_pkg::REASON_OK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      allowed_q <= 1'b0;
      reason_q  <= prag_pkg::REASON_OK;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      if (done_d) begin
        allowed_q <= allowed_d;
        reason_q  <= reason_d;
      end
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign allowed_o = allowed_q;
  assign reason_o  = reason_q;

  `PRAG_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held for more than one cycle")
  `PRAG_ASSERT(a_done_idle, done_q |-> (state_q == ST_IDLE), "result strobe while busy")
  `PRAG_ASSERT_NEXT(a_accept_decode, start_i && (state_q == ST_IDLE), state_q == ST_DECODE, "accepted item not decoded")
  `PRAG_ASSERT(a_allowed_ok, done_q |-> (allowed_q == (reason_q == prag_pkg::REASON_OK)), "allowed disagrees with reason")
  `PRAG_ASSERT(a_match_after_read, (state_q == ST_MATCH) |-> ($past(state_q) == ST_READ), "compare without table read")

endmodule

// File: sv/physical_range_access_gate.sv
// Physical range access gate: region table loader and access range checker.
// Channels: start_i/busy_o take one item (a region load or a range check) at a
// rising edge with start_i high and busy_o low. The result (allowed_o, reason_o)
// is shown for exactly one cycle with done_o high; the receiver cannot stall.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i (0 region
// count, 1 read mask, 2 write mask) with no wait; write only while idle.
// Sequencing: a load, or a check rejected for length, alignment or wrap, is
// decided in the decode state and its strobe is registered from there. A walked
// check then visits the step state once per region stepped through, plus a
// closing visit when the range is covered or the step limit is hit; each table
// entry compared takes a read state and a match state, set by the single read
// port of the region table and its registered read data, and a last read state
// ends the search when it runs out of entries. busy_o drops with the strobe,
// so the next item can be taken in the strobe cycle.
// Reset: region count clears, both masks set to all types allowed, controller
// idles. The region table is not cleared; entries must be loaded before use.
// Depends on prag_pkg, prag_ctrl and prag_dp.
module physical_range_access_gate #(
  parameter int REGION_ENTRIES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [prag_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        command_i,
  input  logic [4:0]                  entry_index_i,
  input  logic [prag_pkg::ADDR_W-1:0] entry_base_i,
  input  logic [prag_pkg::ADDR_W-1:0] entry_length_i,
  input  logic [2:0]                  entry_type_i,
  input  logic [prag_pkg::ADDR_W-1:0] start_address_i,
  input  logic [prag_pkg::ADDR_W-1:0] range_length_i,
  input  logic                        write_access_i,
  input  logic [1:0]                  width_code_i,
  output logic                        done_o,
  output logic                        allowed_o,
  output logic [2:0]                  reason_o
);

  prag_pkg::ctrl_cmd_t  cmd;
  prag_pkg::dp_status_t status;

  prag_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .allowed_o (allowed_o),
    .reason_o  (reason_o)
  );

  prag_dp #(
    .REGION_ENTRIES (REGION_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .entry_base_i    (entry_base_i),
    .entry_length_i  (entry_length_i),
    .entry_type_i    (entry_type_i),
    .start_address_i (start_address_i),
    .range_length_i  (range_length_i),
    .write_access_i  (write_access_i),
    .width_code_i    (width_code_i)
  );

endmodule

// File: test/tb_top.sv
// Self-checking bench for physical_range_access_gate: builds region maps, varies the
// region count and policy masks, and checks every verdict against a walk predictor.
// Depends on prag_pkg and the gate RTL only.
localparam int REGION_SLOTS = 32;
localparam int ITEM_TARGET = 800;
localparam int STALL_LIMIT = 20000;

localparam logic [2:0] KIND_RAM = 3'd0;
localparam logic [2:0] KIND_ACPI = 3'd1;
localparam logic [2:0] KIND_MMIO = 3'd2;
localparam logic [2:0] KIND_RESERVED = 3'd3;
localparam logic [2:0] KIND_SPARE_TOP = 3'd7;

localparam logic [1:0] WIDTH_1 = 2'd0;
localparam logic [1:0] WIDTH_2 = 2'd1;
localparam logic [1:0] WIDTH_4 = 2'd2;
localparam logic [1:0] WIDTH_8 = 2'd3;

localparam logic ACCESS_READ = 1'b0;
localparam logic ACCESS_WRITE = 1'b1;

typedef struct packed {
  logic        command;
  logic [4:0]  entry_index;
  logic [63:0] entry_base;
  logic [63:0] entry_length;
  logic [2:0]  entry_type;
  logic [63:0] start_address;
  logic [63:0] range_length;
  logic        write_access;
  logic [1:0]  width_code;
} gate_item_t;

typedef struct packed {
  logic              allowed;
  prag_pkg::reason_e reason;
} gate_verdict_t;

class range_gate_scoreboard;
  logic [63:0]   region_lo [REGION_SLOTS];
  logic [63:0]   region_len [REGION_SLOTS];
  logic [2:0]    region_kind [REGION_SLOTS];
  logic [5:0]    region_count;
  logic [3:0]    read_policy;
  logic [3:0]    write_policy;
  gate_verdict_t verdicts [$];
  int            errors;

  function new();
    region_count = '0;
    read_policy = 4'hF;
    write_policy = 4'hF;
    errors = 0;
  endfunction

  function void set_reg(prag_pkg::cfg_reg_e idx, logic [5:0] val);
    case (idx)
      prag_pkg::CFG_REGION_COUNT: region_count = val;
      prag_pkg::CFG_READ_MASK:    read_policy = val[3:0];
      prag_pkg::CFG_WRITE_MASK:   write_policy = val[3:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return verdicts.size();
  endfunction

  function prag_pkg::reason_e walk_verdict(logic [63:0] start, logic [63:0] len, logic wr,
                                           logic [1:0] wc);
    logic [63:0] amask;
    logic [63:0] cur;
    logic [63:0] stop;
    logic [64:0] sum;
    logic [64:0] rend;
    logic [3:0]  policy;
    int          n;
    int          hit;
    int          steps;
    int          i;
    amask = (64'd1 << wc) - 64'd1;
    if (len == '0) return prag_pkg::REASON_ZERO_LEN;
    if (((start | len) & amask) != '0) return prag_pkg::REASON_MISALIGNED;
    sum = {1'b0, start} + {1'b0, len};
    if (sum[64]) return prag_pkg::REASON_WRAPS;
    stop = sum[63:0];
    policy = wr ? write_policy : read_policy;
    n = (region_count > REGION_SLOTS) ? REGION_SLOTS : int'(region_count);
    cur = start;
    for (steps = 0; steps <= REGION_SLOTS && cur < stop; steps++) begin
      hit = -1;
      for (i = 0; i < n && hit < 0; i++)
        if (cur >= region_lo[i] && cur - region_lo[i] < region_len[i]) hit = i;
      if (hit < 0) return prag_pkg::REASON_UNCOVERED;
      if (region_kind[hit] >= prag_pkg::KIND_UNMAPPED) return prag_pkg::REASON_UNCOVERED;
      if (!policy[region_kind[hit][1:0]]) return prag_pkg::REASON_POLICY;
      rend = {1'b0, region_lo[hit]} + {1'b0, region_len[hit]};
      if (rend[64]) return prag_pkg::REASON_OK;
      cur = rend[63:0];
    end
    return prag_pkg::REASON_OK;
  endfunction

  function void note_item(gate_item_t it);
    gate_verdict_t v;
    if (it.command == prag_pkg::CMD_LOAD) begin
      region_lo[it.entry_index] = it.entry_base;
      region_len[it.entry_index] = it.entry_length;
      region_kind[it.entry_index] = it.entry_type;
      v.reason = prag_pkg::REASON_OK;
    end else begin
      v.reason = walk_verdict(it.start_address, it.range_length, it.write_access,
                              it.width_code);
    end
    v.allowed = (v.reason == prag_pkg::REASON_OK);
    verdicts.push_back(v);
  endfunction

  function void check_result(logic allowed, logic [2:0] reason);
    gate_verdict_t v;
    if (verdicts.size() == 0) begin
      $error("result with no item pending: allowed %0d reason %0d", allowed, reason);
      errors++;
      return;
    end
    v = verdicts.pop_front();
    if (allowed !== v.allowed) begin
      $error("allowed: expected %0d, got %0d", v.allowed, allowed);
      errors++;
    end
    if (reason !== v.reason) begin
      $error("reason: expected %0d, got %0d", v.reason, reason);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic                        cfg_we_i;
  logic [1:0]                  cfg_index_i;
  logic [prag_pkg::CFG_W-1:0]  cfg_data_i;
  logic                        command_i;
  logic [4:0]                  entry_index_i;
  logic [prag_pkg::ADDR_W-1:0] entry_base_i;
  logic [prag_pkg::ADDR_W-1:0] entry_length_i;
  logic [2:0]                  entry_type_i;
  logic [prag_pkg::ADDR_W-1:0] start_address_i;
  logic [prag_pkg::ADDR_W-1:0] range_length_i;
  logic                        write_access_i;
  logic [1:0]                  width_code_i;
  logic                        done_o;
  logic                        allowed_o;
  logic [2:0]                  reason_o;

  range_gate_scoreboard sb;
  bit                   slot_loaded [REGION_SLOTS];
  logic [63:0]          map_lo;
  logic [63:0]          map_span;
  int                   items_sent;
  int                   stall_cycles;

  physical_range_access_gate #(
    .REGION_ENTRIES(REGION_SLOTS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .command_i(command_i),
    .entry_index_i(entry_index_i),
    .entry_base_i(entry_base_i),
    .entry_length_i(entry_length_i),
    .entry_type_i(entry_type_i),
    .start_address_i(start_address_i),
    .range_length_i(range_length_i),
    .write_access_i(write_access_i),
    .width_code_i(width_code_i),
    .done_o(done_o),
    .allowed_o(allowed_o),
    .reason_o(reason_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(allowed_o, reason_o);
      if (done_o || (start_i && !busy_o)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[physical_range_access_gate] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic gate_item_t rand_item();
    gate_item_t it;
    it.command = rand_bit();
    it.entry_index = 5'($urandom_range(0, REGION_SLOTS - 1));
    it.entry_base = rand64();
    it.entry_length = rand64();
    it.entry_type = 3'($urandom_range(0, 7));
    it.start_address = rand64();
    it.range_length = rand64();
    it.write_access = rand_bit();
    it.width_code = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic gate_item_t mk_load(int idx, logic [63:0] base, logic [63:0] len,
                                         logic [2:0] kind);
    gate_item_t it;
    it = rand_item();
    it.command = prag_pkg::CMD_LOAD;
    it.entry_index = idx[4:0];
    it.entry_base = base;
    it.entry_length = len;
    it.entry_type = kind;
    return it;
  endfunction

  function automatic gate_item_t mk_check(logic [63:0] start, logic [63:0] len, logic wr,
                                          logic [1:0] wc);
    gate_item_t it;
    it = rand_item();
    it.command = prag_pkg::CMD_CHECK;
    it.start_address = start;
    it.range_length = len;
    it.write_access = wr;
    it.width_code = wc;
    return it;
  endfunction

  function automatic int loaded_prefix();
    for (int i = 0; i < REGION_SLOTS; i++)
      if (!slot_loaded[i]) return i;
    return REGION_SLOTS;
  endfunction

  function automatic gate_item_t gen_check();
    logic [1:0]  wc;
    logic [63:0] w;
    logic [63:0] off;
    logic [63:0] lim;
    logic [63:0] len;
    int          k;
    wc = 2'($urandom_range(0, 3));
    w = 64'd1 << wc;
    if ($urandom_range(0, 99) < 70 && map_span != '0) begin
      off = (rand64() % map_span) & ~(w - 64'd1);
      lim = map_span - off;
      if ($urandom_range(0, 1) && lim > 64'd256) lim = 64'd256;
      len = (rand64() % lim) + 64'd1;
      len = (len + w - 64'd1) & ~(w - 64'd1);
      if ($urandom_range(0, 9) == 0) len += w << $urandom_range(0, 8);
      return mk_check(map_lo + off, len, rand_bit(), wc);
    end
    k = $urandom_range(0, 4);
    case ($urandom_range(0, 5))
      0: return mk_check(rand64(), rand64(), rand_bit(), wc);
      1: return mk_check(rand64(), '0, rand_bit(), wc);
      2: return mk_check(64'hFFFF_FFFF_FFFF_FFF8 - (64'(k) << 3),
                         64'(k + 1 + $urandom_range(0, 2)) << 3,
                         rand_bit(), WIDTH_8);
      3: return mk_check(map_lo + 64'(2 * k + 1), 64'($urandom_range(1, 64)),
                         rand_bit(), 2'($urandom_range(1, 3)));
      4: return mk_check(map_lo - (64'(k + 1) << 3), 64'($urandom_range(1, 8)) << 3,
                         rand_bit(), WIDTH_8);
      default: return mk_check(rand64(), 64'($urandom_range(1, 64)),
                               rand_bit(), WIDTH_1);
    endcase
  endfunction

  task automatic send_item(input gate_item_t it);
    @(negedge clk_i);
    start_i = 1'b1;
    command_i = it.command;
    entry_index_i = it.entry_index;
    entry_base_i = it.entry_base;
    entry_length_i = it.entry_length;
    entry_type_i = it.entry_type;
    start_address_i = it.start_address;
    range_length_i = it.range_length;
    write_access_i = it.write_access;
    width_code_i = it.width_code;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(it);
    if (it.command == prag_pkg::CMD_LOAD) slot_loaded[it.entry_index] = 1'b1;
    items_sent++;
  endtask

  task automatic idle_for(input int n);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain();
    idle_for(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic maybe_idle();
    int r;
    r = $urandom_range(0, 99);
    if (items_sent < ITEM_TARGET - 100) begin
      if (r < 2) drain();
      else if (r < 30) idle_for($urandom_range(1, 12));
    end
  endtask

  task automatic write_reg(input prag_pkg::cfg_reg_e idx, input logic [5:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [5:0] pick_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 6'd0;
    if (r < 3) return 6'd15;
    return 6'($urandom_range(0, 15));
  endfunction

  task automatic configure_phase();
    int         prefix;
    int         r;
    logic [5:0] cnt;
    prefix = loaded_prefix();
    r = $urandom_range(0, 9);
    if (r == 0) cnt = '0;
    else if (r < 4) cnt = 6'(prefix);
    else if (prefix == REGION_SLOTS && r < 6) cnt = 6'($urandom_range(33, 63));
    else cnt = 6'($urandom_range(0, prefix));
    write_reg(prag_pkg::CFG_REGION_COUNT, cnt);
    write_reg(prag_pkg::CFG_READ_MASK, pick_mask());
    write_reg(prag_pkg::CFG_WRITE_MASK, pick_mask());
  endtask

  task automatic load_map(input int n);
    logic [63:0] cursor;
    logic [63:0] len;
    logic [2:0]  kind;
    bit          near_top;
    int          r;
    r = $urandom_range(0, 9);
    near_top = (r == 1);
    if (r == 0) cursor = '0;
    else if (near_top) cursor = 64'hFFFF_FFFF_FFF0_0000;
    else cursor = rand64() & 64'h7FFF_FFFF_FFFF_F000;
    map_lo = cursor;
    for (int i = 0; i < n; i++) begin
      len = 64'($urandom_range(1, 64)) << $urandom_range(0, 6);
      r = $urandom_range(0, 99);
      if (r < 80) kind = 3'($urandom_range(0, 3));
      else if (r < 90) kind = prag_pkg::KIND_UNMAPPED;
      else kind = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 19) == 0) len = '0;
      if ($urandom_range(0, 19) == 0) cursor += 64'($urandom_range(1, 8)) << 3;
      if (near_top && i == n - 1) len = 64'd0 - cursor;
      send_item(mk_load(i, cursor, len, kind));
      maybe_idle();
      if ($urandom_range(0, 19) != 0) cursor += len;
    end
    map_span = cursor - map_lo;
  endtask

  initial begin
    int n;
    int phase;
    sb = new();
    rst_ni = 1'b0;
    start_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = prag_pkg::CFG_REGION_COUNT;
    cfg_data_i = '0;
    command_i = prag_pkg::CMD_LOAD;
    entry_index_i = '0;
    entry_base_i = '0;
    entry_length_i = '0;
    entry_type_i = KIND_RAM;
    start_address_i = '0;
    range_length_i = '0;
    write_access_i = ACCESS_READ;
    width_code_i = WIDTH_1;
    items_sent = 0;
    stall_cycles = 0;
    map_lo = '0;
    map_span = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // rejects ahead of any walk, then an empty table
    send_item(mk_check(64'h1000, '0, ACCESS_READ, WIDTH_1));
    send_item(mk_check(64'h1004, 64'd8, ACCESS_READ, WIDTH_8));
    send_item(mk_check(64'h1000, 64'd6, ACCESS_WRITE, WIDTH_4));
    send_item(mk_check(64'hFFFF_FFFF_FFFF_FFF0, 64'd32, ACCESS_READ, WIDTH_8));
    send_item(mk_check(64'hFFFF_FFFF_FFFF_FFF8, 64'd8, ACCESS_WRITE, WIDTH_8));
    send_item(mk_check('0, 64'd1, ACCESS_READ, WIDTH_1));

    send_item(mk_load(0, 64'h1000, 64'h1000, KIND_RAM));
    send_item(mk_load(1, 64'h2000, 64'h1000, KIND_ACPI));
    send_item(mk_load(2, 64'h3000, 64'h1000, KIND_MMIO));
    send_item(mk_load(3, 64'h4000, 64'h1000, KIND_RESERVED));
    send_item(mk_load(4, 64'h5000, 64'h1000, prag_pkg::KIND_UNMAPPED));
    send_item(mk_load(5, 64'h6000, 64'h1000, KIND_SPARE_TOP));
    send_item(mk_load(6, 64'h7000, '0, KIND_RAM));
    send_item(mk_load(7, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, KIND_RAM));
    send_item(mk_load(8, 64'hFFFF_FFFF_FFFF_0000, '1, KIND_ACPI));
    send_item(mk_load(9, '1, '1, KIND_RESERVED));
    drain();
    write_reg(prag_pkg::CFG_REGION_COUNT, 6'd10);

    send_item(mk_check(64'h1000, 64'h4000, ACCESS_READ, WIDTH_8));
    send_item(mk_check(64'h1000, 64'h5000, ACCESS_WRITE, WIDTH_2));
    send_item(mk_check(64'h6000, 64'd8, ACCESS_READ, WIDTH_8));
    send_item(mk_check(64'h7000, 64'd4, ACCESS_READ, WIDTH_4));
    send_item(mk_check(64'hFFFF_FFFF_FFFF_F000, 64'h800, ACCESS_READ, WIDTH_8));
    send_item(mk_check(64'hFFFF_FFFF_FFFF_0000, 64'hF000, ACCESS_READ, WIDTH_1));
    drain();
    write_reg(prag_pkg::CFG_READ_MASK, 6'd0);
    write_reg(prag_pkg::CFG_WRITE_MASK, 6'b001101);
    send_item(mk_check(64'h2000, 64'h10, ACCESS_WRITE, WIDTH_4));
    send_item(mk_check(64'h1000, 64'd8, ACCESS_READ, WIDTH_8));
    send_item(mk_check(64'h1000, 64'h1000, ACCESS_WRITE, WIDTH_1));
    drain();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      load_map((phase % 5 == 0) ? REGION_SLOTS : $urandom_range(1, 8));
      drain();
      configure_phase();
      if (phase == 0) write_reg(prag_pkg::CFG_REGION_COUNT, 6'd63);
      n = $urandom_range(20, 50);
      repeat (n) begin
        if ($urandom_range(0, 24) == 0) begin
          send_item(mk_load($urandom_range(0, REGION_SLOTS - 1), rand64(), rand64(),
                            3'($urandom_range(0, 7))));
        end else begin
          send_item(gen_check());
        end
        maybe_idle();
      end
      drain();
      phase++;
    end

    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[physical_range_access_gate] OK");
    end else begin
      $display("[physical_range_access_gate] ERROR");
    end
    $finish;
  end
endmodule
